@@ design/password_keystream_byte_cipher_defines.svh @@
// Assertion macros for the password keystream byte cipher checker.
// Included by the checker file; depends on nothing else.
`ifndef PASSWORD_KEYSTREAM_BYTE_CIPHER_DEFINES_SVH
`define PASSWORD_KEYSTREAM_BYTE_CIPHER_DEFINES_SVH

// Same-cycle implication, sampled on clk, switched off while rst_n is low.
`define PKB_CHECK_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, switched off while rst_n is low.
`define PKB_CHECK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/pkb_pkg.sv @@
// Shared constants, types and helper functions of the password keystream byte cipher.
// Used by every module of the block but pkb_ram; depends on nothing.
`default_nettype none

package pkb_pkg;

  localparam int MAX_KEY_BYTES = 32;
  localparam int ROWS          = MAX_KEY_BYTES / 8;
  localparam int ROW_W         = $clog2(ROWS);
  localparam int PTR_W         = $clog2(MAX_KEY_BYTES);
  localparam int LEN_W         = PTR_W + 1;
  localparam int DATA_W        = 16;
  localparam int CFG_W         = 64;
  localparam int CFG_IDX_W     = 3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_KEY0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY3 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LEN  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MODE = 3'd5;

  // Read ports of the key store.
  localparam int RP_K     = 0;
  localparam int RP_A     = 1;
  localparam int RP_B     = 2;
  localparam int RP_T     = 3;
  localparam int RP_H     = 4;
  localparam int RP_DG    = 5;
  localparam int RD_PORTS = 6;

  localparam logic [LEN_W-1:0] MIN_LEN = LEN_W'(2);
  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_KEY_BYTES);

  typedef struct packed {
    logic [7:0] k;
    logic [7:0] a;
    logic [7:0] b;
    logic [7:0] t;
    logic [7:0] h;
  } kbytes_t;

  function automatic logic [7:0] key_byte(input logic [63:0] row, input logic [2:0] sel);
    key_byte = row[{sel, 3'b000} +: 8];
  endfunction

  function automatic logic [DATA_W-1:0] sext8(input logic [7:0] b);
    sext8 = {{8{b[7]}}, b};
  endfunction

  function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] len);
    if (len < MIN_LEN) begin
      clamp_len = MIN_LEN;
    end else if (len > MAX_LEN) begin
      clamp_len = MAX_LEN;
    end else begin
      clamp_len = len;
    end
  endfunction

endpackage

`default_nettype wire

@@ design/pkb_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; no package dependency.
`default_nettype none

module pkb_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ design/pkb_keystore.sv @@
// Key store: copies of the 32-byte password, one RAM per read port, with row valid bits.
// Depends on pkb_pkg and pkb_ram.
`default_nettype none

module pkb_keystore (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       wr_en,
  input  wire logic [pkb_pkg::ROW_W-1:0]  wr_row,
  input  wire logic [pkb_pkg::CFG_W-1:0]  wr_data,
  input  wire logic [pkb_pkg::ROW_W-1:0]  rd_row  [pkb_pkg::RD_PORTS],
  output logic      [pkb_pkg::CFG_W-1:0]  rd_data [pkb_pkg::RD_PORTS]
);

  // A row never written since reset reads as zero.
  logic [pkb_pkg::ROWS-1:0]     vld_r;
  logic [pkb_pkg::RD_PORTS-1:0] rvld_r;
  logic [pkb_pkg::CFG_W-1:0]    ram_q [pkb_pkg::RD_PORTS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      rvld_r <= '0;
    end else begin
      if (wr_en) begin
        vld_r[wr_row] <= 1'b1;
      end
      for (int p = 0; p < pkb_pkg::RD_PORTS; p++) begin
        rvld_r[p] <= vld_r[rd_row[p]];
      end
    end
  end

  for (genvar p = 0; p < pkb_pkg::RD_PORTS; p++) begin : g_port
    pkb_ram #(
      .WIDTH (pkb_pkg::CFG_W),
      .DEPTH (pkb_pkg::ROWS)
    ) u_ram (
      .clk   (clk),
      .we    (wr_en),
      .waddr (wr_row),
      .wdata (wr_data),
      .raddr (rd_row[p]),
      .rdata (ram_q[p])
    );

    assign rd_data[p] = rvld_r[p] ? ram_q[p] : '0;
  end

endmodule

`default_nettype wire

@@ design/pkb_digest.sv @@
// Key digest unit: sweeps the password one byte per cycle after reset or a configuration write.
// Depends on pkb_pkg; reads the key store through one dedicated port.
`default_nettype none

module pkb_digest (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [pkb_pkg::LEN_W-1:0]   n_len,
  input  wire logic [pkb_pkg::CFG_W-1:0]   row_data,
  output logic      [pkb_pkg::ROW_W-1:0]   row_addr,
  output logic                             busy,
  output logic      [pkb_pkg::DATA_W-1:0]  digest
);

  logic                        busy_r;
  logic [pkb_pkg::LEN_W-1:0]   iss_r;
  logic                        pro_v_r;
  logic [pkb_pkg::PTR_W-1:0]   pro_idx_r;
  logic [pkb_pkg::DATA_W-1:0]  total_r;
  logic [pkb_pkg::DATA_W-1:0]  xsum_r;
  logic [pkb_pkg::DATA_W-1:0]  prev_r;
  logic [pkb_pkg::DATA_W-1:0]  dg_r;

  logic                        issue;
  logic                        last;
  logic [pkb_pkg::LEN_W-1:0]   n_m1;
  logic [pkb_pkg::DATA_W-1:0]  byte_v;
  logic [pkb_pkg::DATA_W-1:0]  total_nxt;
  logic [pkb_pkg::DATA_W-1:0]  xsum_nxt;

  assign issue     = busy_r && (iss_r < n_len);
  assign row_addr  = iss_r[pkb_pkg::PTR_W-1:3];
  assign n_m1      = n_len - pkb_pkg::LEN_W'(1);
  assign byte_v    = pkb_pkg::sext8(pkb_pkg::key_byte(row_data, pro_idx_r[2:0]));
  assign total_nxt = total_r + byte_v;
  assign xsum_nxt  = (pro_idx_r != '0) ? xsum_r + (byte_v ^ prev_r) : xsum_r;
  assign last      = pro_v_r && (pro_idx_r == n_m1[pkb_pkg::PTR_W-1:0]);

  always_ff @(posedge clk) begin
    if (!rst_n || start) begin
      busy_r  <= 1'b1;
      iss_r   <= '0;
      pro_v_r <= 1'b0;
      total_r <= '0;
      xsum_r  <= '0;
    end else begin
      pro_v_r <= issue;
      if (issue) begin
        iss_r <= iss_r + pkb_pkg::LEN_W'(1);
      end
      if (pro_v_r) begin
        total_r <= total_nxt;
        xsum_r  <= xsum_nxt;
      end
      if (last) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    pro_idx_r <= iss_r[pkb_pkg::PTR_W-1:0];
    if (pro_v_r) begin
      prev_r <= byte_v;
    end
    if (last) begin
      dg_r <= ~total_nxt ^ xsum_nxt;
    end
  end

  assign busy   = busy_r;
  assign digest = dg_r;

endmodule

`default_nettype wire

@@ design/pkb_core.sv @@
// Datapath of the cipher: input register, keystream arithmetic and result register.
// Depends on pkb_pkg.
`default_nettype none

module pkb_core (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        accept,
  input  wire logic [pkb_pkg::DATA_W-1:0]  data_in,
  input  wire pkb_pkg::kbytes_t            kb,
  input  wire logic                        decrypt,
  input  wire logic [pkb_pkg::DATA_W-1:0]  digest,
  output logic                             ready,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic      [pkb_pkg::DATA_W-1:0]  out_data
);

  logic                        s1_v_r;
  logic                        s1_v_nxt;
  logic [pkb_pkg::DATA_W-1:0]  d_r;
  pkb_pkg::kbytes_t            kb_r;
  logic                        out_v_r;
  logic                        out_v_nxt;
  logic [pkb_pkg::DATA_W-1:0]  out_d_r;
  logic                        s1_move;

  logic [pkb_pkg::DATA_W-1:0]  k16;
  logic [pkb_pkg::DATA_W-1:0]  a16;
  logic [pkb_pkg::DATA_W-1:0]  b16;
  logic [pkb_pkg::DATA_W-1:0]  t16;
  logic [pkb_pkg::DATA_W-1:0]  h16;
  logic signed [pkb_pkg::DATA_W-1:0] prod;
  logic [pkb_pkg::DATA_W-1:0]  terms;
  logic [pkb_pkg::DATA_W-1:0]  enc_w;
  logic [pkb_pkg::DATA_W-1:0]  dec_w;
  logic [pkb_pkg::DATA_W-1:0]  res;

  assign s1_move   = s1_v_r && (!out_v_r || out_ready);
  assign ready     = !s1_v_r || s1_move;
  assign s1_v_nxt  = accept || (s1_v_r && !s1_move);
  assign out_v_nxt = s1_move || (out_v_r && !out_ready);

  assign k16  = pkb_pkg::sext8(kb_r.k);
  assign a16  = pkb_pkg::sext8(kb_r.a);
  assign b16  = pkb_pkg::sext8(kb_r.b);
  assign t16  = pkb_pkg::sext8(kb_r.t);
  assign h16  = pkb_pkg::sext8(kb_r.h);
  // The low 16 bits of the product of the widened bytes equal the exact signed 8x8 product.
  assign prod = $signed(t16) * $signed(h16);

  assign terms = (a16 + b16) + (a16 - b16) + prod + (t16 + h16);
  assign enc_w = ((pkb_pkg::sext8(d_r[7:0]) ^ k16) + terms) ^ digest;
  assign dec_w = (d_r ^ digest) - terms;
  assign res   = decrypt ? {8'h00, dec_w[7:0] ^ kb_r.k} : enc_w;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      d_r  <= data_in;
      kb_r <= kb;
    end
    if (s1_move) begin
      out_d_r <= res;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_d_r;

endmodule

`default_nettype wire

@@ design/password_keystream_byte_cipher.sv @@
// Top level of the password keystream byte cipher: configuration registers, key pointers,
// key store, digest unit and datapath. Depends on pkb_pkg, pkb_keystore, pkb_digest, pkb_core.
//
//   Channel  Direction  Handshake               Payload
//   in_      sink       in_valid / in_ready     in_data_in[15:0]
//   out_     source     out_valid / out_ready   out_data_out[15:0]
//   cfg_     sink       cfg_we (no back-pressure) cfg_index[2:0], cfg_wdata[63:0]
//
// One request is taken per cycle while in_ready is high. A taken request sits in the input
// register; the keystream arithmetic (one small multiply and adds) lies between it and the
// result register, which drives out_valid. Reset is synchronous and active low. in_ready is
// low in a configuration write cycle and after the write (or after reset) while the digest
// unit sweeps the password one byte per cycle through its own key store port.
// When out_ready is low the result register holds its request and one more request can
// wait in the input register; in_ready then drops until the output drains.
`default_nettype none

module password_keystream_byte_cipher (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [pkb_pkg::DATA_W-1:0]    in_data_in,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic      [pkb_pkg::DATA_W-1:0]    out_data_out,
  input  wire logic                          cfg_we,
  input  wire logic [pkb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [pkb_pkg::CFG_W-1:0]     cfg_wdata
);

  // Configuration registers. The key bytes themselves live in the key store RAMs.
  logic [pkb_pkg::LEN_W-1:0]  key_length_r;
  logic                       decrypt_mode_r;

  // Key pointers. They are kept already wrapped into range, so each one always holds the
  // index that the next request will use. The key store is addressed with the next value,
  // which makes its registered read data line up with the current pointers.
  logic [pkb_pkg::PTR_W-1:0]  kp_r, kp_nxt;
  logic [pkb_pkg::PTR_W-1:0]  pp_r, pp_nxt;
  logic [pkb_pkg::PTR_W-1:0]  rp_r, rp_nxt;
  logic [pkb_pkg::PTR_W-1:0]  fp_r, fp_nxt;
  logic [pkb_pkg::PTR_W-1:0]  pb_cur;
  logic [pkb_pkg::PTR_W-1:0]  pb_nxt;

  logic [pkb_pkg::LEN_W-1:0]  n_len;
  logic [pkb_pkg::LEN_W-1:0]  n_m1;
  logic [pkb_pkg::LEN_W-1:0]  n_m2;

  logic                       key_we;
  logic [pkb_pkg::ROW_W-1:0]  rd_row  [pkb_pkg::RD_PORTS];
  logic [pkb_pkg::CFG_W-1:0]  rd_data [pkb_pkg::RD_PORTS];
  logic [pkb_pkg::ROW_W-1:0]  dg_row;
  logic                       dg_busy;
  logic [pkb_pkg::DATA_W-1:0] dg_value;

  pkb_pkg::kbytes_t           kb;
  logic                       core_ready;
  logic                       accept;

  assign n_len = pkb_pkg::clamp_len(key_length_r);
  assign n_m1  = n_len - pkb_pkg::LEN_W'(1);
  assign n_m2  = n_len - pkb_pkg::LEN_W'(2);

  // No request is taken during a configuration write or while the digest is rebuilt.
  assign in_ready = !dg_busy && !cfg_we && core_ready;
  assign accept   = in_valid && in_ready;

  // Configuration writes. Any write, even to an index beyond the list, restarts the
  // pointers; that happens through the digest unit, which goes busy on every write.
  assign key_we = cfg_we && (cfg_index <= pkb_pkg::REG_KEY3);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_length_r   <= pkb_pkg::MIN_LEN;
      decrypt_mode_r <= 1'b0;
    end else if (cfg_we) begin
      if (cfg_index == pkb_pkg::REG_LEN) begin
        key_length_r <= cfg_wdata[pkb_pkg::LEN_W-1:0];
      end
      if (cfg_index == pkb_pkg::REG_MODE) begin
        decrypt_mode_r <= cfg_wdata[0];
      end
    end
  end

  // Pointer update. While the digest is rebuilt the pointers sit at their start values,
  // which are computed from the length already written, so they are right once ready rises.
  // The key and pair pointers wrap to zero; the falling pointer counts down to one and
  // then reloads to the last byte.
  always_comb begin
    kp_nxt = kp_r;
    pp_nxt = pp_r;
    rp_nxt = rp_r;
    fp_nxt = fp_r;
    if (dg_busy || cfg_we) begin
      kp_nxt = '0;
      pp_nxt = '0;
      rp_nxt = '0;
      fp_nxt = n_m1[pkb_pkg::PTR_W-1:0];
    end else if (accept) begin
      kp_nxt = (kp_r == n_m1[pkb_pkg::PTR_W-1:0]) ? '0 : kp_r + pkb_pkg::PTR_W'(1);
      pp_nxt = (pp_r == n_m2[pkb_pkg::PTR_W-1:0]) ? '0 : pp_r + pkb_pkg::PTR_W'(1);
      rp_nxt = (rp_r == n_m2[pkb_pkg::PTR_W-1:0]) ? '0 : rp_r + pkb_pkg::PTR_W'(1);
      fp_nxt = (fp_r == pkb_pkg::PTR_W'(1)) ? n_m1[pkb_pkg::PTR_W-1:0]
                                            : fp_r - pkb_pkg::PTR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_r <= '0;
      pp_r <= '0;
      rp_r <= '0;
      fp_r <= pkb_pkg::PTR_W'(1);
    end else begin
      kp_r <= kp_nxt;
      pp_r <= pp_nxt;
      rp_r <= rp_nxt;
      fp_r <= fp_nxt;
    end
  end

  // The pair pointer never passes the second-to-last byte, so its neighbour stays in range.
  assign pb_cur = pp_r + pkb_pkg::PTR_W'(1);
  assign pb_nxt = pp_nxt + pkb_pkg::PTR_W'(1);

  assign rd_row[pkb_pkg::RP_K]  = kp_nxt[pkb_pkg::PTR_W-1:3];
  assign rd_row[pkb_pkg::RP_A]  = pp_nxt[pkb_pkg::PTR_W-1:3];
  assign rd_row[pkb_pkg::RP_B]  = pb_nxt[pkb_pkg::PTR_W-1:3];
  assign rd_row[pkb_pkg::RP_T]  = rp_nxt[pkb_pkg::PTR_W-1:3];
  assign rd_row[pkb_pkg::RP_H]  = fp_nxt[pkb_pkg::PTR_W-1:3];
  assign rd_row[pkb_pkg::RP_DG] = dg_row;

  pkb_keystore u_keystore (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (key_we),
    .wr_row  (cfg_index[pkb_pkg::ROW_W-1:0]),
    .wr_data (cfg_wdata),
    .rd_row  (rd_row),
    .rd_data (rd_data)
  );

  pkb_digest u_digest (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cfg_we),
    .n_len    (n_len),
    .row_data (rd_data[pkb_pkg::RP_DG]),
    .row_addr (dg_row),
    .busy     (dg_busy),
    .digest   (dg_value)
  );

  // Byte selection within each row read for the current pointers.
  assign kb.k = pkb_pkg::key_byte(rd_data[pkb_pkg::RP_K], kp_r[2:0]);
  assign kb.a = pkb_pkg::key_byte(rd_data[pkb_pkg::RP_A], pp_r[2:0]);
  assign kb.b = pkb_pkg::key_byte(rd_data[pkb_pkg::RP_B], pb_cur[2:0]);
  assign kb.t = pkb_pkg::key_byte(rd_data[pkb_pkg::RP_T], rp_r[2:0]);
  assign kb.h = pkb_pkg::key_byte(rd_data[pkb_pkg::RP_H], fp_r[2:0]);

  pkb_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .data_in   (in_data_in),
    .kb        (kb),
    .decrypt   (decrypt_mode_r),
    .digest    (dg_value),
    .ready     (core_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data_out)
  );

endmodule

`default_nettype wire

@@ design/pkb_checker.sv @@
// Port-level checker for the password keystream byte cipher, attached by bind.
// Depends on password_keystream_byte_cipher_defines.svh and pkb_pkg.
`default_nettype none
`include "password_keystream_byte_cipher_defines.svh"

module pkb_checker (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          in_valid,
  input wire logic                          in_ready,
  input wire logic                          out_valid,
  input wire logic                          out_ready,
  input wire logic [pkb_pkg::DATA_W-1:0]    out_data_out,
  input wire logic                          cfg_we
);

  `PKB_CHECK_NOW(a_no_take_on_cfg, cfg_we, !in_ready, "request taken during a configuration write")
  `PKB_CHECK_NEXT(a_rebuild_after_cfg, cfg_we, !in_ready, "ready high while digest is rebuilt")
  `PKB_CHECK_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data_out), "stalled result changed")
  `PKB_CHECK_NOW(a_result_follows, $past(in_valid && in_ready, 2), out_valid, "no result two cycles after a request")
  `PKB_CHECK_NOW(a_result_has_source, $rose(out_valid), $past(in_valid && in_ready, 2), "result without a request")

endmodule

bind password_keystream_byte_cipher pkb_checker u_pkb_checker (.*);

`default_nettype wire

@@ bench/tb.sv @@
// Self-checking bench for the password keystream byte cipher. It needs only pkb_pkg and
// the cipher top level, and carries its own predictor of the key pointers and keystream.
module tb;
  import pkb_pkg::*;

  // The two indexes past the register list. A write there changes no register,
  // but it still restarts all four key pointers.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = REG_MODE + 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = REG_MODE + 3'd2;
  localparam int RANDOM_WORDS = 1500;
  localparam int CYCLE_LIMIT  = 400000;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [DATA_W-1:0]    in_data_in = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [DATA_W-1:0]    out_data_out;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  password_keystream_byte_cipher u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data_in   (in_data_in),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data_out (out_data_out),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the cipher's registers and key pointers.
  logic [63:0] key_rows [4];
  logic [5:0]  key_len_reg;
  logic        decrypting;
  logic [4:0]  ptr_key, ptr_pair, ptr_up, ptr_down;

  logic [DATA_W-1:0] data_backlog [$];   // requests waiting to be offered
  logic [DATA_W-1:0] predicted_out [$];  // results owed by the cipher, oldest first
  int n_queued  = 0;
  int n_matched = 0;
  int fails     = 0;
  int cycles    = 0;
  int hold_in   = 0;
  int hold_out  = 0;
  int wait_out  = 0;
  bit quiet_in  = 1'b0;
  bit quiet_out = 1'b0;
  logic [DATA_W-1:0] want;

  // Signed password byte at position idx, widened to the 16-bit datapath.
  function automatic logic [15:0] key_at(input logic [4:0] idx);
    logic [7:0] b;
    b = key_rows[idx[4:3]][{idx[2:0], 3'b000} +: 8];
    key_at = {{8{b[7]}}, b};
  endfunction

  // Advances the shadow pointers by one request and returns the word the cipher owes.
  function automatic logic [15:0] cipher_step(input logic [15:0] din);
    logic [5:0]  n;
    logic [15:0] total, xsum, digest, k, a, b, t, h, terms, w;
    n = (key_len_reg < 6'd2) ? 6'd2 :
        (key_len_reg > 6'(MAX_KEY_BYTES)) ? 6'(MAX_KEY_BYTES) : key_len_reg;
    total = '0;
    xsum  = '0;
    for (int i = 0; i < n; i++) begin
      total = total + key_at(5'(i));
      if (i > 0) begin
        xsum = xsum + (key_at(5'(i)) ^ key_at(5'(i - 1)));
      end
    end
    digest = ~total ^ xsum;

    if (ptr_key >= n) begin
      ptr_key = '0;
    end
    k = key_at(ptr_key);
    ptr_key = ptr_key + 5'd1;

    if (ptr_pair >= n - 6'd1) begin
      ptr_pair = '0;
    end
    a = key_at(ptr_pair);
    b = key_at(ptr_pair + 5'd1);
    ptr_pair = ptr_pair + 5'd1;

    // A falling pointer of zero, or one at or beyond the end of the key, is reloaded from the top.
    if (ptr_up >= n - 6'd1) begin
      ptr_up = '0;
    end
    if (ptr_down == 5'd0 || ptr_down >= n) begin
      ptr_down = 5'(n - 6'd1);
    end
    t = key_at(ptr_up);
    h = key_at(ptr_down);
    ptr_up   = ptr_up + 5'd1;
    ptr_down = ptr_down - 5'd1;

    terms = (a + b) + (a - b) + (t * h) + (t + h);
    if (decrypting) begin
      w = (din ^ digest) - terms;
      cipher_step = {8'h00, w[7:0] ^ k[7:0]};
    end else begin
      // The top byte of a plaintext request plays no part.
      w = ({{8{din[7]}}, din[7:0]} ^ k) + terms;
      cipher_step = w ^ digest;
    end
  endfunction

  task automatic shadow_write(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
    if (idx <= REG_KEY3) begin
      key_rows[idx[1:0]] = val;
    end else if (idx == REG_LEN) begin
      key_len_reg = val[5:0];
    end else if (idx == REG_MODE) begin
      decrypting = val[0];
    end
    ptr_key  = '0;
    ptr_pair = '0;
    ptr_up   = '0;
    ptr_down = '0;
  endtask

  // Back-to-back writes keep cfg_we high; cfg_close lowers it after the last one.
  task automatic cfg_put(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    shadow_write(idx, val);
  endtask

  task automatic cfg_close();
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic offer(input logic [15:0] w);
    data_backlog.push_back(w);
    n_queued++;
  endtask

  // Returns once every request handed to the driver has had its result checked.
  task automatic settle();
    while (n_matched != n_queued) begin
      @(posedge clk);
    end
  endtask

  function automatic logic [63:0] key_row_draw();
    logic [7:0] fill;
    if ($urandom_range(0, 3) == 0) begin
      case ($urandom_range(0, 3))
        0: fill = 8'h80;
        1: fill = 8'h7F;
        2: fill = 8'hFF;
        default: fill = 8'h00;
      endcase
      key_row_draw = {8{fill}};
    end else begin
      key_row_draw = {$urandom, $urandom};
    end
  endfunction

  // Driver: offers one request at a time from the backlog, with a random wait
  // after each one. The prediction is made at the edge where the request is taken.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid   <= 1'b0;
      in_data_in <= '0;
      hold_in    <= 0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) begin
        predicted_out.push_back(cipher_step(in_data_in));
      end
      if (hold_in != 0) begin
        in_valid <= 1'b0;
        hold_in  <= hold_in - 1;
      end else if (data_backlog.size() != 0) begin
        in_valid   <= 1'b1;
        in_data_in <= data_backlog.pop_front();
        hold_in    <= quiet_in ? 0 : $urandom_range(0, 6);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: checks each result against the oldest prediction, and draws a fresh
  // stall for out_ready after every result it takes; a stall of zero keeps it high.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      hold_out  <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (predicted_out.size() == 0) begin
          $error("data_out: no result expected, got %h", out_data_out);
          fails++;
        end else begin
          want = predicted_out.pop_front();
          n_matched++;
          if (out_data_out !== want) begin
            $error("data_out: expected %h, got %h", want, out_data_out);
            fails++;
          end
        end
        wait_out = quiet_out ? 0 : $urandom_range(0, 6);
        hold_out <= wait_out;
        if (wait_out != 0) begin
          out_ready <= 1'b0;
        end
      end else if (!out_ready) begin
        if (hold_out <= 1) begin
          out_ready <= 1'b1;
          hold_out  <= 0;
        end else begin
          hold_out <= hold_out - 1;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  initial begin : stimulus
    int target;
    int words;
    // Reset values of the shadow registers.
    for (int r = 0; r < 4; r++) begin
      key_rows[r] = '0;
    end
    key_len_reg = 6'd2;
    decrypting  = 1'b0;
    ptr_key  = '0;
    ptr_pair = '0;
    ptr_up   = '0;
    ptr_down = '0;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: an all-zero two-byte password, encrypting. The top byte of
    // a plaintext request must be ignored, so some requests carry garbage there.
    offer(16'h0000);
    offer(16'h007F);
    offer(16'h0080);
    offer(16'h00FF);
    offer(16'hFF00);
    offer(16'hFFFF);
    settle();

    // Every byte at its most negative, and a length above the maximum, which the
    // cipher must treat as the full 32 bytes.
    for (int r = 0; r < 4; r++) begin
      cfg_put(REG_KEY0 + CFG_IDX_W'(r), {8{8'h80}});
    end
    cfg_put(REG_LEN, 64'd63);
    cfg_put(REG_MODE, 64'd0);
    cfg_close();
    offer(16'h0000);
    offer(16'h0080);
    offer(16'h007F);
    offer(16'h5A80);
    settle();

    // Every byte at its most positive, length zero (taken as two), decrypting.
    for (int r = 0; r < 4; r++) begin
      cfg_put(REG_KEY0 + CFG_IDX_W'(r), {8{8'h7F}});
    end
    cfg_put(REG_LEN, 64'd0);
    cfg_put(REG_MODE, 64'd1);
    cfg_close();
    offer(16'h0000);
    offer(16'hFFFF);
    offer(16'h8000);
    offer(16'h7FFF);
    settle();

    // Length one (taken as two) with noisy unused bytes that must play no part,
    // then a write past the register list, which only restarts the pointers.
    cfg_put(REG_KEY0, 64'h0123_4567_89AB_CDEF);
    cfg_put(REG_KEY0 + 3'd1, 64'hFFFF_FFFF_FFFF_FFFF);
    cfg_put(REG_LEN, 64'd1);
    cfg_put(REG_SPARE_LO, 64'hFFFF_FFFF_FFFF_FFFF);
    cfg_close();
    offer(16'h0000);
    offer(16'hFFFF);
    offer(16'h8000);
    settle();

    // Length just past the maximum, encrypting, and the other spare index.
    cfg_put(REG_KEY0 + 3'd2, 64'hFF00_FF00_80_7F_01_FE);
    cfg_put(REG_KEY3, 64'hFFFF_FFFF_FFFF_FFFF);
    cfg_put(REG_LEN, 64'd33);
    cfg_put(REG_MODE, 64'd0);
    cfg_put(REG_SPARE_HI, 64'd0);
    cfg_close();
    offer(16'h00FF);
    offer(16'hA500);
    offer(16'h0001);
    settle();

    // Random phases: a fresh mix of register writes between phases, then a run of
    // random requests. Some phases run without any idling on one side or both.
    target = n_queued + RANDOM_WORDS;
    while (n_queued < target) begin
      for (int idx = 0; idx <= int'(REG_MODE); idx++) begin
        if ($urandom_range(0, 1) == 1) begin
          if (idx <= int'(REG_KEY3)) begin
            cfg_put(CFG_IDX_W'(idx), key_row_draw());
          end else if (idx == int'(REG_LEN)) begin
            if ($urandom_range(0, 5) == 0) begin
              cfg_put(REG_LEN, 64'($urandom_range(0, 63)));
            end else begin
              cfg_put(REG_LEN, 64'($urandom_range(2, MAX_KEY_BYTES)));
            end
          end else begin
            cfg_put(REG_MODE, 64'($urandom));
          end
        end
      end
      if ($urandom_range(0, 7) == 0) begin
        cfg_put($urandom_range(0, 1) ? REG_SPARE_HI : REG_SPARE_LO, {$urandom, $urandom});
      end
      cfg_close();
      quiet_in  = ($urandom_range(0, 3) == 0);
      quiet_out = ($urandom_range(0, 3) == 0);
      words = $urandom_range(40, 110);
      repeat (words) offer(16'($urandom_range(0, 65535)));
      settle();
    end

    // Nothing is owed any more; let the clock run on so that any stray result shows.
    repeat (10) @(posedge clk);
    if (fails == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
